// ===== src/vertex_project_to_screen_macros.svh =====
// Assertion macros shared by the vertex projection block.
`ifndef VERTEX_PROJECT_TO_SCREEN_MACROS_SVH
`define VERTEX_PROJECT_TO_SCREEN_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define VPTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define VPTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vpts_pkg.sv =====
// Types, constants and helpers of the vertex projection block.
package vpts_pkg;

  localparam int FracBits  = 16;
  localparam int DataW     = 32;
  localparam int DivW      = DataW + FracBits;
  localparam int HalfW     = 13;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int NumEntry  = 16;
  localparam int EntryIdxW = 4;

  typedef logic signed [DataW-1:0] fix_t;

  localparam fix_t FixOne  = fix_t'(64'sd1 <<< FracBits);
  localparam fix_t FixMax  = 32'sh7FFFFFFF;
  localparam fix_t FixMin  = 32'sh80000000;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_XFORM = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_WIDTH  = 2'd0,
    CFG_HALF_HEIGHT = 2'd1
  } cfg_idx_e;

  // Homogeneous x, y, z, w of one point.
  typedef struct packed {
    fix_t [3:0] h;
  } homog_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic fix_t sat32(input logic signed [63:0] v);
    if (v > 64'(FixMax)) return FixMax;
    if (v < 64'(FixMin)) return FixMin;
    return v[DataW-1:0];
  endfunction

endpackage

// ===== src/vpts_if.sv =====
// Request, result and configuration channel interfaces.
interface vpts_req_if import vpts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [EntryIdxW-1:0] entry_index;
  fix_t                 entry_value;
  fix_t                 pos_x;
  fix_t                 pos_y;
  fix_t                 pos_z;

  modport source (output valid, mode, entry_index, entry_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, mode, entry_index, entry_value, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface vpts_res_if import vpts_pkg::*; ();
  logic valid;
  logic ready;
  fix_t screen_x;
  fix_t screen_y;
  fix_t depth;
  logic inside_res;
  logic w_zero;

  modport source (output valid, screen_x, screen_y, depth, inside_res, w_zero,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, depth, inside_res, w_zero,
                  output ready);
endinterface

interface vpts_cfg_if import vpts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/vpts_front.sv =====
// Front end: request intake, matrix store and homogeneous transform.
module vpts_front import vpts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vpts_req_if.sink   req_i,
  output logic       push_vld_o,
  output homog_t     push_data_o,
  input  fifo_stat_t fifo_stat_i
);

  fix_t mat_q [NumEntry];
  logic signed [63:0] prod_q [3][4];
  fix_t bias_q [4];
  logic s1_vld_q, s2_vld_q;
  homog_t s2_q, s2_d;
  logic adv, acc;
  fix_t pos [3];

  assign adv         = !s2_vld_q || !fifo_stat_i.full;
  assign acc         = req_i.valid && adv;
  assign req_i.ready = adv;
  assign push_vld_o  = s2_vld_q && !fifo_stat_i.full;
  assign push_data_o = s2_q;

  assign pos[0] = req_i.pos_x;
  assign pos[1] = req_i.pos_y;
  assign pos[2] = req_i.pos_z;

  always_ff @(posedge clk_i) begin
    if (acc && mode_e'(req_i.mode) == MODE_LOAD) begin
      mat_q[req_i.entry_index] <= req_i.entry_value;
    end
  end

  // Products are floored when summed: arithmetic shift.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s2_d.h[c] = sat32((prod_q[0][c] >>> FracBits) + (prod_q[1][c] >>> FracBits)
                      + (prod_q[2][c] >>> FracBits) + 64'(bias_q[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= pos[r] * mat_q[r*4+c];
        end
      end
      for (int c = 0; c < 4; c++) begin
        bias_q[c] <= mat_q[12+c];
      end
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= acc && mode_e'(req_i.mode) == MODE_XFORM;
      s2_vld_q <= s1_vld_q;
    end
  end

endmodule

// ===== src/vpts_fifo.sv =====
// Short queue of homogeneous points between front and back end.
module vpts_fifo import vpts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  homog_t     push_data_i,
  input  logic       pop_i,
  output homog_t     pop_data_o,
  output fifo_stat_t stat_o
);

  homog_t mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;

  assign stat_o.full  = cnt_q == (FifoPtrW+1)'(FifoDepth);
  assign stat_o.empty = cnt_q == '0;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoPtrW+1)'(push_i) - (FifoPtrW+1)'(pop_i);
    end
  end

endmodule

// ===== src/vpts_back.sv =====
// Back end: pipelined perspective divide, viewport map and result register.
module vpts_back import vpts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  homog_t           pop_data_i,
  input  fifo_stat_t       fifo_stat_i,
  output logic             pop_o,
  input  logic [HalfW-1:0] half_width_i,
  input  logic [HalfW-1:0] half_height_i,
  vpts_res_if.source       res_o
);

  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DivW-1:0]  nq;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]      ln;
    logic [DataW-1:0] dvs;
    logic             wz;
  } dstage_t;

  localparam logic [DivW-1:0] PosLim = {{(DivW-DataW){1'b0}}, 32'h7FFFFFFF};
  localparam logic [DivW-1:0] NegLim = {{(DivW-DataW){1'b0}}, 32'h80000000};

  dstage_t dstg_q [DivW+1];
  dstage_t dnext  [DivW+1];
  logic [DivW:0] dvld_q;

  fix_t ndc_q [3];
  logic a_vld_q, a_wz_q;
  fix_t ndc_d [3];

  logic out_vld_q, out_in_q, out_wz_q;
  fix_t out_sx_q, out_sy_q, out_nz_q;
  logic adv;

  logic signed [DataW+HalfW:0] px, py;
  logic signed [63:0] offs_w, offs_h;
  fix_t w;

  assign adv   = !out_vld_q || res_o.ready;
  assign pop_o = adv && !fifo_stat_i.empty;
  assign w     = pop_data_i.h[3];

  always_comb begin
    dnext[0].dvs = w[DataW-1] ? DataW'(-w) : w;
    dnext[0].wz  = w == '0;
    for (int l = 0; l < 3; l++) begin
      dnext[0].ln[l].rem = '0;
      dnext[0].ln[l].neg = pop_data_i.h[l][DataW-1] ^ w[DataW-1];
      dnext[0].ln[l].nq  = {(pop_data_i.h[l][DataW-1] ? DataW'(-pop_data_i.h[l])
                                                      : pop_data_i.h[l]),
                            {FracBits{1'b0}}};
    end
    // One quotient bit per stage, restoring.
    for (int k = 0; k < DivW; k++) begin
      logic [DataW:0] t;
      logic           ge;
      dnext[k+1] = dstg_q[k];
      for (int l = 0; l < 3; l++) begin
        t  = {dstg_q[k].ln[l].rem, dstg_q[k].ln[l].nq[DivW-1]};
        ge = t >= {1'b0, dstg_q[k].dvs};
        dnext[k+1].ln[l].rem = ge ? DataW'(t - {1'b0, dstg_q[k].dvs}) : t[DataW-1:0];
        dnext[k+1].ln[l].nq  = {dstg_q[k].ln[l].nq[DivW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dstg_q[0] <= dnext[0];
      for (int k = 0; k < DivW; k++) begin
        dstg_q[k+1] <= dnext[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else if (adv) begin
      dvld_q <= {dvld_q[DivW-1:0], pop_o};
    end
  end

  // Apply sign and saturate the quotient.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!dstg_q[DivW].ln[l].neg) begin
        ndc_d[l] = (dstg_q[DivW].ln[l].nq > PosLim) ? FixMax
                                                    : dstg_q[DivW].ln[l].nq[DataW-1:0];
      end else begin
        ndc_d[l] = (dstg_q[DivW].ln[l].nq > NegLim) ? FixMin
                                                    : -dstg_q[DivW].ln[l].nq[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ndc_q  <= ndc_d;
      a_wz_q <= dstg_q[DivW].wz;
    end
  end

  always_comb begin
    px     = ndc_q[0] * $signed({1'b0, half_width_i});
    py     = ndc_q[1] * $signed({1'b0, half_height_i});
    offs_w = $signed(64'(half_width_i)) <<< FracBits;
    offs_h = $signed(64'(half_height_i)) <<< FracBits;
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_vld_q) begin
      out_wz_q <= a_wz_q;
      if (a_wz_q) begin
        out_sx_q <= '0;
        out_sy_q <= '0;
        out_nz_q <= '0;
        out_in_q <= 1'b0;
      end else begin
        out_sx_q <= sat32(64'(px) + offs_w);
        out_sy_q <= sat32(offs_h - 64'(py));
        out_nz_q <= ndc_q[2];
        out_in_q <= ndc_q[0] <= FixOne && ndc_q[0] >= -FixOne &&
                    ndc_q[1] <= FixOne && ndc_q[1] >= -FixOne && !ndc_q[2][DataW-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= dvld_q[DivW];
      out_vld_q <= a_vld_q;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.screen_x   = out_sx_q;
  assign res_o.screen_y   = out_sy_q;
  assign res_o.depth      = out_nz_q;
  assign res_o.inside_res = out_in_q;
  assign res_o.w_zero     = out_wz_q;

endmodule

// ===== src/vertex_project_to_screen.sv =====
// Top level of the vertex projection block.
// Takes one request per cycle, load or transform, unless a full queue stalls the front
// end. A load writes its matrix entry at acceptance, and a transform accepted in the
// very next cycle already sees it. A transform passes two front stages (12 multipliers,
// then the column sums), a four-entry queue, a divider pipeline of 32+FRAC_BITS stages
// that works one quotient bit per stage for x, y and z at once, a sign and saturation
// stage and the viewport stage that loads the result register. Throughput stays one
// per cycle while results are taken. Loads return no result.
`include "vertex_project_to_screen_macros.svh"

module vertex_project_to_screen import vpts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vpts_req_if.sink   req_i,
  vpts_res_if.source res_o,
  vpts_cfg_if.sink   cfg_i
);

  logic [HalfW-1:0] half_width_q, half_height_q;
  logic       push_vld, pop;
  homog_t     push_data, pop_data;
  fifo_stat_t fifo_stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= HalfW'(640);
      half_height_q <= HalfW'(360);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HALF_WIDTH:  half_width_q  <= cfg_i.data[HalfW-1:0];
        CFG_HALF_HEIGHT: half_height_q <= cfg_i.data[HalfW-1:0];
        default: ;
      endcase
    end
  end

  vpts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .push_vld_o  (push_vld),
    .push_data_o (push_data),
    .fifo_stat_i (fifo_stat)
  );

  vpts_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_vld),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  vpts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_data_i    (pop_data),
    .fifo_stat_i   (fifo_stat),
    .pop_o         (pop),
    .half_width_i  (half_width_q),
    .half_height_i (half_height_q),
    .res_o         (res_o)
  );

  `VPTS_ASSERT_IMP(a_stall_full, !req_i.ready, fifo_stat.full, "front stalled, queue not full")
  `VPTS_ASSERT_IMP(a_wzero_clean, res_o.valid && res_o.w_zero,
                   !res_o.inside_res && res_o.screen_x == '0 && res_o.depth == '0,
                   "zero w result not cleared")
  `VPTS_ASSERT_IMP(a_inside_front, res_o.valid && res_o.inside_res, !res_o.depth[DataW-1],
                   "inside point behind the eye")
  `VPTS_ASSERT_NXT(a_cfg_width, cfg_i.valid && cfg_i.index == CFG_HALF_WIDTH,
                   half_width_q == $past(cfg_i.data[HalfW-1:0]), "half width not written")

endmodule

// ===== dv/tb_vertex_project_to_screen.sv =====
// Self-checking testbench for the vertex projection block: directed table, then random requests.
`timescale 1ns / 100ps

module tb_vertex_project_to_screen;
  import vpts_pkg::*;

  localparam int DrainCycles = 80;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 20000;
  localparam int PhaseItems  = 330;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;

  typedef struct {
    mode_e                mode;
    logic [EntryIdxW-1:0] idx;
    fix_t                 val;
    fix_t                 x;
    fix_t                 y;
    fix_t                 z;
  } vtx_req_t;

  typedef struct {
    fix_t sx;
    fix_t sy;
    fix_t dep;
    logic in_clip;
    logic wz;
  } pixel_t;

  typedef struct {
    vtx_req_t rq;
    bit       typed;
    pixel_t   want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  vpts_req_if req_if ();
  vpts_res_if res_if ();
  vpts_cfg_if cfg_if ();

  vertex_project_to_screen u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  fix_t        mat_copy [NumEntry];
  logic [12:0] half_w;
  logic [12:0] half_h;
  pixel_t      pixel_q [$];
  dir_row_t    dir_rows [$];
  int          mismatches;
  bit          hold_req;
  bit          no_idle;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic fix_t clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pixel_t project_point(fix_t x, fix_t y, fix_t z);
    logic signed [63:0] xl, yl, zl, s, num, one, wid, hei;
    fix_t   h [4];
    fix_t   nx, ny, nz;
    pixel_t p;
    xl = x;
    yl = y;
    zl = z;
    for (int c = 0; c < 4; c++) begin
      s = ((xl * 64'(mat_copy[c])) >>> FracBits) + ((yl * 64'(mat_copy[4+c])) >>> FracBits)
        + ((zl * 64'(mat_copy[8+c])) >>> FracBits) + 64'(mat_copy[12+c]);
      h[c] = clamp32(s);
    end
    p = '{sx: '0, sy: '0, dep: '0, in_clip: 1'b0, wz: 1'b0};
    if (h[3] == 0) begin
      p.wz = 1'b1;
      return p;
    end
    num = 64'(h[0]) <<< FracBits;
    nx = clamp32(num / 64'(h[3]));
    num = 64'(h[1]) <<< FracBits;
    ny = clamp32(num / 64'(h[3]));
    num = 64'(h[2]) <<< FracBits;
    nz = clamp32(num / 64'(h[3]));
    one = 64'sd1 <<< FracBits;
    wid = {51'd0, half_w};
    hei = {51'd0, half_h};
    p.sx = clamp32(64'(nx) * wid + wid * one);
    p.sy = clamp32(-64'(ny) * hei + hei * one);
    p.dep = nz;
    p.in_clip = (64'(nx) <= one) && (64'(nx) >= -one) && (64'(ny) <= one)
             && (64'(ny) >= -one) && (nz >= 0);
    return p;
  endfunction

  function automatic int rand_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic fix_t rand_fix(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return FixMax;
        1: return FixMin;
        2: return '0;
        3: return FixOne;
        default: return -FixOne;
      endcase
    end
    if (r < 3) return fix_t'($urandom);
    return fix_t'($urandom_range(0, 2 * span)) - fix_t'(span);
  endfunction

  task automatic report_mismatch(string what, fix_t got, fix_t want);
    $display("MISMATCH %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // Offer one request; the expected pixel is queued at acceptance.
  task automatic send_vertex(vtx_req_t rq, bit typed, pixel_t want);
    int n;
    n = rand_gap();
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= rq.mode;
    req_if.entry_index <= rq.idx;
    req_if.entry_value <= rq.val;
    req_if.pos_x       <= rq.x;
    req_if.pos_y       <= rq.y;
    req_if.pos_z       <= rq.z;
    do @(posedge clk_i); while (!req_if.ready);
    if (rq.mode == MODE_LOAD) begin
      mat_copy[rq.idx] = rq.val;
    end else begin
      pixel_q.push_back(typed ? want : project_point(rq.x, rq.y, rq.z));
    end
  endtask

  task automatic drain_pipe();
    req_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_HALF_WIDTH) half_w = data[12:0];
    else if (idx == CFG_HALF_HEIGHT) half_h = data[12:0];
    @(posedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        n = rand_gap();
        if (n == 0) begin
          res_if.ready <= 1'b1;
        end else begin
          res_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected result", res_if.screen_x, '0);
      end else begin
        want = pixel_q.pop_front();
        if (res_if.screen_x !== want.sx) report_mismatch("screen_x", res_if.screen_x, want.sx);
        if (res_if.screen_y !== want.sy) report_mismatch("screen_y", res_if.screen_y, want.sy);
        if (res_if.depth !== want.dep) report_mismatch("depth", res_if.depth, want.dep);
        if (res_if.inside_res !== want.in_clip) begin
          report_mismatch("inside_res", fix_t'(res_if.inside_res), fix_t'(want.in_clip));
        end
        if (res_if.w_zero !== want.wz) begin
          report_mismatch("w_zero", fix_t'(res_if.w_zero), fix_t'(want.wz));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
          || (cfg_if.valid && cfg_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles", idle);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    vtx_req_t rq;
    pixel_t   zero_px;
    pixel_t   none;
    logic [CfgDataW-1:0] cw, ch;
    int       r;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_LOAD;
    req_if.entry_index = '0;
    req_if.entry_value = '0;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.pos_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_HALF_WIDTH;
    cfg_if.data = '0;
    mismatches = 0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    half_w = 13'd640;
    half_h = 13'd360;
    for (int i = 0; i < NumEntry; i++) mat_copy[i] = '0;
    zero_px = '{sx: '0, sy: '0, dep: '0, in_clip: 1'b0, wz: 1'b1};
    none = '{sx: '0, sy: '0, dep: '0, in_clip: 1'b0, wz: 1'b0};

    // Identity matrix first: every entry is written before any transform.
    for (int i = 0; i < NumEntry; i++) begin
      dir_rows.push_back('{rq: '{MODE_LOAD, 4'(i), (i % 5 == 0) ? FixOne : fix_t'(0),
                                 fix_t'($urandom), fix_t'($urandom), fix_t'($urandom)},
                          typed: 1'b0, want: none});
    end
    dir_rows.push_back('{rq: '{MODE_XFORM, 4'd15, FixMin, '0, '0, '0}, typed: 1'b1,
                         want: '{sx: 32'sd41943040, sy: 32'sd23592960, dep: '0,
                                 in_clip: 1'b1, wz: 1'b0}});
    dir_rows.push_back('{rq: '{MODE_XFORM, 4'd0, FixMax, FixOne, FixOne, '0}, typed: 1'b1,
                         want: '{sx: 32'sd83886080, sy: '0, dep: '0,
                                 in_clip: 1'b1, wz: 1'b0}});
    dir_rows.push_back('{rq: '{MODE_XFORM, 4'd7, '0, FixMax, FixMin, FixMax},
                         typed: 1'b0, want: none});
    dir_rows.push_back('{rq: '{MODE_XFORM, 4'd3, '0, '0, '0, -FixOne},
                         typed: 1'b0, want: none});
    dir_rows.push_back('{rq: '{MODE_LOAD, 4'd0, FixMin, FixMax, FixMax, FixMax},
                         typed: 1'b0, want: none});
    dir_rows.push_back('{rq: '{MODE_XFORM, 4'd15, FixMax, FixMin, '0, '0},
                         typed: 1'b0, want: none});
    // Zero w: homogeneous w comes only from entry 15 at the origin.
    dir_rows.push_back('{rq: '{MODE_LOAD, 4'd15, '0, '0, '0, '0}, typed: 1'b0, want: none});
    dir_rows.push_back('{rq: '{MODE_XFORM, 4'd9, 32'sh5A5A5A5A, '0, '0, '0}, typed: 1'b1,
                         want: zero_px});
    dir_rows.push_back('{rq: '{MODE_LOAD, 4'd15, FixMax, '0, '0, '0}, typed: 1'b0, want: none});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_vertex(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      drain_pipe();
      case (ph)
        0: begin cw = '0; ch = '0; end
        1: begin cw = 32'd4096; ch = 32'd4096; end
        2: begin cw = 32'hFFFFFFFF; ch = 32'h00001FFF; end
        3: begin cw = $urandom_range(0, 4096); ch = $urandom_range(0, 4096); end
        default: begin cw = 32'hABCD0280; ch = 32'd360; end
      endcase
      write_reg(CFG_HALF_WIDTH, cw);
      write_reg(CFG_HALF_HEIGHT, ch);
      if (ph == 2) begin
        write_reg(CfgIdxSpare2, $urandom);
        write_reg(CfgIdxSpare3, $urandom);
      end
      no_idle = (ph == 3);
      for (int k = 0; k < PhaseItems; k++) begin
        if (ph == 1 && k == 100) hold_req = 1'b1;
        if (ph == 2 && k == 200) drain_pipe();
        r = $urandom_range(0, 99);
        rq.idx = 4'($urandom);
        rq.val = ($urandom_range(0, 19) == 0) ? fix_t'(0) : rand_fix(2 <<< FracBits);
        rq.x = rand_fix(4 <<< FracBits);
        rq.y = rand_fix(4 <<< FracBits);
        rq.z = rand_fix(4 <<< FracBits);
        if (r < 30) begin
          rq.mode = MODE_LOAD;
        end else begin
          rq.mode = MODE_XFORM;
          if (r < 33) begin
            rq.x = '0;
            rq.y = '0;
            rq.z = '0;
          end
        end
        send_vertex(rq, 1'b0, none);
      end
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== vertex_project_to_screen.f =====
+incdir+src
src/vpts_pkg.sv
src/vpts_if.sv
src/vpts_front.sv
src/vpts_fifo.sv
src/vpts_back.sv
src/vertex_project_to_screen.sv
dv/tb_vertex_project_to_screen.sv
